>>> design/vlmba_pkg.sv
// Shared types and codes for the message buffer allocator.
`timescale 1ns / 1ps
`default_nettype none

package vlmba_pkg;

    localparam int REGION_W = 17;
    localparam int ID_W     = 32;
    localparam int LEN_W    = 16;

    localparam logic [1:0] FN_PUT   = 2'd0;
    localparam logic [1:0] FN_GET   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_PUT  = 2'd1,
        SRC_GET  = 2'd2
    } src_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [ID_W-1:0]  msg_id;
        logic [LEN_W-1:0] msg_len;
    } cmd_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  out_id;
        logic [LEN_W-1:0] out_offset;
        logic [LEN_W-1:0] out_len;
        logic             queue_empty;
        logic             queue_full;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [REGION_W-1:0] offset;
        logic [LEN_W-1:0]    len;
    } desc_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    put;
        logic    clear;
        logic    rd;
        logic    rel;
        logic    merge;
        logic    fin;
        src_t    src;
        status_t status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       full;
        logic       fits;
    } stat_t;

endpackage

`default_nettype wire

>>> design/vlmba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module vlmba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/vlmba_ctrl.sv
// Operation sequencer for the message buffer allocator.
`timescale 1ns / 1ps
`default_nettype none

module vlmba_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire vlmba_pkg::stat_t st,
    output vlmba_pkg::ctl_t      ctl,
    output logic                 busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_REL   = 4'b0100,
        S_MERGE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        ctl.src    = vlmba_pkg::SRC_NONE;
        ctl.status = vlmba_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.fin    = 1'b1;
                state_next = S_IDLE;
                case (st.func)
                    vlmba_pkg::FN_PUT:
                    begin
                        if (st.full)
                        begin
                            ctl.status = vlmba_pkg::ST_FULL;
                        end
                        else if (st.fits)
                        begin
                            ctl.put = 1'b1;
                            ctl.src = vlmba_pkg::SRC_PUT;
                        end
                        else
                        begin
                            ctl.status = vlmba_pkg::ST_NOSPACE;
                        end
                    end
                    vlmba_pkg::FN_GET:
                    begin
                        if (st.empty)
                        begin
                            ctl.status = vlmba_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // fetch the oldest descriptor, finish after release and merge
                            ctl.fin    = 1'b0;
                            ctl.rd     = 1'b1;
                            state_next = S_REL;
                        end
                    end
                    vlmba_pkg::FN_CLEAR:
                    begin
                        if (st.empty)
                        begin
                            ctl.clear = 1'b1;
                        end
                        else
                        begin
                            ctl.status = vlmba_pkg::ST_IGNORED;
                        end
                    end
                    default:
                    begin
                        ctl.status = vlmba_pkg::ST_IGNORED;
                    end
                endcase
            end
            S_REL:
            begin
                ctl.rel    = 1'b1;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                ctl.merge  = 1'b1;
                ctl.fin    = 1'b1;
                ctl.src    = vlmba_pkg::SRC_GET;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_rd_then_rel: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd |=> (state_reg == S_REL))
        else $error("descriptor read not followed by release");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.latch |-> (!busy && start))
        else $error("transaction latched while busy");

    a_fin_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin |-> !ctl.rd && !ctl.latch)
        else $error("finish overlaps read or accept");

endmodule

`default_nettype wire

>>> design/vlmba_dp.sv
// Free-region registers, descriptor queue and result register.
`timescale 1ns / 1ps
`default_nettype none

module vlmba_dp #(
    parameter int BUF_BYTES = 65536,
    parameter int MSG_SLOTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vlmba_pkg::cmd_t    cmd,
    input  wire vlmba_pkg::ctl_t    ctl,
    output vlmba_pkg::stat_t        st,
    output vlmba_pkg::result_t      result,
    output logic                    done
);

    localparam int RW    = vlmba_pkg::REGION_W;
    localparam int PTR_W = (MSG_SLOTS > 1) ? $clog2(MSG_SLOTS) : 1;
    localparam int CNT_W = $clog2(MSG_SLOTS + 1);
    localparam logic [RW-1:0]    BUF_VAL  = RW'(BUF_BYTES);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MSG_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MSG_SLOTS);

    vlmba_pkg::cmd_t    cmd_reg;
    vlmba_pkg::result_t result_reg, result_next;
    logic               done_reg;

    logic [RW-1:0] head_start_reg, head_start_next;
    logic [RW-1:0] head_room_reg,  head_room_next;
    logic [RW-1:0] tail_start_reg, tail_start_next;
    logic [RW-1:0] tail_room_reg,  tail_room_next;
    logic [RW-1:0] last_end_reg,   last_end_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic [RW-1:0]   len17;
    logic            use_tail;
    logic            use_head;
    logic [RW-1:0]   put_off;
    vlmba_pkg::desc_t wr_desc;
    vlmba_pkg::desc_t rd_desc;
    logic [RW-1:0]   rel_len;
    logic [RW-1:0]   head_end;

    vlmba_ram #(
        .WIDTH ($bits(vlmba_pkg::desc_t)),
        .DEPTH (MSG_SLOTS)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ctl.put),
        .waddr (wr_ptr_reg),
        .wdata (wr_desc),
        .re    (ctl.rd),
        .raddr (rd_ptr_reg),
        .rdata (rd_desc)
    );

    assign len17    = {1'b0, cmd_reg.msg_len};
    assign use_tail = (last_end_reg == tail_start_reg) && (tail_room_reg > len17);
    assign use_head = !use_tail && (head_room_reg > len17);
    assign put_off  = use_tail ? tail_start_reg : head_start_reg;

    assign wr_desc.id     = cmd_reg.msg_id;
    assign wr_desc.offset = put_off;
    assign wr_desc.len    = cmd_reg.msg_len;

    assign rel_len  = {1'b0, rd_desc.len};
    assign head_end = head_start_reg + head_room_reg;

    assign st.func  = cmd_reg.func;
    assign st.empty = (count_reg == '0);
    assign st.full  = (count_reg == CNT_FULL);
    assign st.fits  = use_tail || use_head;

    always_comb
    begin
        head_start_next = head_start_reg;
        head_room_next  = head_room_reg;
        tail_start_next = tail_start_reg;
        tail_room_next  = tail_room_reg;
        last_end_next   = last_end_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;

        if (ctl.put)
        begin
            if (use_tail)
            begin
                tail_start_next = tail_start_reg + len17;
                tail_room_next  = tail_room_reg - len17;
            end
            else
            begin
                head_start_next = head_start_reg + len17;
                head_room_next  = head_room_reg - len17;
            end
            last_end_next = put_off + len17;
            wr_ptr_next   = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            count_next    = count_reg + 1'b1;
        end

        if (ctl.clear)
        begin
            head_start_next = '0;
            head_room_next  = BUF_VAL;
            tail_start_next = BUF_VAL;
            tail_room_next  = '0;
            last_end_next   = '0;
        end

        // zero-length messages leave the regions alone, merge included
        if (ctl.rel && (rel_len != '0))
        begin
            if (rd_desc.offset < head_start_reg)
            begin
                tail_start_next = head_start_reg;
                tail_room_next  = head_room_reg;
                head_start_next = rd_desc.offset;
                head_room_next  = rel_len;
            end
            else
            begin
                head_room_next = head_room_reg + rel_len;
            end
        end

        if (ctl.merge)
        begin
            if ((rel_len != '0) && (head_end == tail_start_reg))
            begin
                head_room_next  = head_room_reg + tail_room_reg;
                tail_start_next = BUF_VAL;
                tail_room_next  = '0;
            end
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        result_next             = result_reg;
        result_next.status      = ctl.status;
        result_next.queue_empty = (count_next == '0);
        result_next.queue_full  = (count_next == CNT_FULL);
        case (ctl.src)
            vlmba_pkg::SRC_PUT:
            begin
                result_next.out_id     = '0;
                result_next.out_offset = put_off[vlmba_pkg::LEN_W-1:0];
                result_next.out_len    = cmd_reg.msg_len;
            end
            vlmba_pkg::SRC_GET:
            begin
                result_next.out_id     = rd_desc.id;
                result_next.out_offset = rd_desc.offset[vlmba_pkg::LEN_W-1:0];
                result_next.out_len    = rd_desc.len;
            end
            default:
            begin
                result_next.out_id     = '0;
                result_next.out_offset = '0;
                result_next.out_len    = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= cmd;
        end
        if (ctl.fin)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_start_reg <= '0;
            head_room_reg  <= BUF_VAL;
            tail_start_reg <= BUF_VAL;
            tail_room_reg  <= '0;
            last_end_reg   <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            head_start_reg <= head_start_next;
            head_room_reg  <= head_room_next;
            tail_start_reg <= tail_start_next;
            tail_room_reg  <= tail_room_next;
            last_end_reg   <= last_end_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            done_reg       <= ctl.fin;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("descriptor count above slot count");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_FULL) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("full queue with pointers apart");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.merge |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> design/variable_length_message_buffer_allocator_top.sv
// Top level of the variable-length message buffer allocator.
//
//  channel   ports                  transfer
//  command   start, busy, cmd       taken at an edge with start high, busy low
//  result    done, result           done high one cycle; receiver cannot stall
//
//  Put, clear, failed get and unknown op: done is high in the cycle after
//  the execute cycle.
//  Successful get: a registered descriptor RAM read, then the two-step
//  release/merge of the free regions; done follows the merge cycle.
//  Reset is asynchronous; regions return to their initial layout, the queue
//  empties and the descriptor RAM content is left as is.
`timescale 1ns / 1ps
`default_nettype none

module variable_length_message_buffer_allocator_top #(
    parameter int BUF_BYTES = 65536,
    parameter int MSG_SLOTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire vlmba_pkg::cmd_t    cmd,
    output logic                    busy,
    output logic                    done,
    output vlmba_pkg::result_t      result
);

    vlmba_pkg::ctl_t  ctl;
    vlmba_pkg::stat_t st;

    vlmba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .ctl   (ctl),
        .busy  (busy)
    );

    vlmba_dp #(
        .BUF_BYTES (BUF_BYTES),
        .MSG_SLOTS (MSG_SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .st     (st),
        .result (result),
        .done   (done)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the variable-length message buffer allocator.
`timescale 1ns / 1ps

module testbench;

    localparam int BUF_BYTES = 65536;
    localparam int MSG_SLOTS = 64;

    // func value that the block has no operation for
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef enum int {
        FILLING,
        DRAINING,
        MIXED
    } traffic_t;

    // Tracks free regions and the descriptor FIFO, predicts one result per transaction.
    class msg_alloc_tracker;
        bit [16:0]   head_start;
        bit [16:0]   head_room;
        bit [16:0]   tail_start;
        bit [16:0]   tail_room;
        bit [16:0]   last_end;
        logic [31:0] slot_id [MSG_SLOTS];
        bit [16:0]   slot_off [MSG_SLOTS];
        bit [15:0]   slot_len [MSG_SLOTS];
        int          rd_ptr;
        int          wr_ptr;
        int          used;
        vlmba_pkg::result_t pending[$];
        int          errors;

        function new();
            reset_regions();
            rd_ptr = 0;
            wr_ptr = 0;
            used   = 0;
            errors = 0;
        endfunction

        function void reset_regions();
            head_start = '0;
            head_room  = 17'(BUF_BYTES);
            tail_start = 17'(BUF_BYTES);
            tail_room  = '0;
            last_end   = '0;
        endfunction

        function void note_command(vlmba_pkg::cmd_t c);
            vlmba_pkg::result_t r;
            bit [16:0] off;
            bit [16:0] len17;
            bit [16:0] head_end;
            bit [15:0] len;
            bit        granted;
            r = '0;
            r.status = vlmba_pkg::ST_OK;
            len17 = {1'b0, c.msg_len};
            granted = 1'b1;
            case (c.func)
                vlmba_pkg::FN_PUT:
                begin
                    if (used >= MSG_SLOTS)
                        r.status = vlmba_pkg::ST_FULL;
                    else
                    begin
                        if (last_end == tail_start && tail_room > len17)
                        begin
                            off = tail_start;
                            tail_start = tail_start + len17;
                            tail_room  = tail_room - len17;
                        end
                        else if (head_room > len17)
                        begin
                            off = head_start;
                            head_start = head_start + len17;
                            head_room  = head_room - len17;
                        end
                        else
                            granted = 1'b0;
                        if (granted)
                        begin
                            slot_id[wr_ptr]  = c.msg_id;
                            slot_off[wr_ptr] = off;
                            slot_len[wr_ptr] = c.msg_len;
                            wr_ptr = (wr_ptr + 1) % MSG_SLOTS;
                            used++;
                            last_end = off + len17;
                            r.out_offset = off[15:0];
                            r.out_len = c.msg_len;
                        end
                        else
                            r.status = vlmba_pkg::ST_NOSPACE;
                    end
                end
                vlmba_pkg::FN_GET:
                begin
                    if (used == 0)
                        r.status = vlmba_pkg::ST_EMPTY;
                    else
                    begin
                        off = slot_off[rd_ptr];
                        len = slot_len[rd_ptr];
                        r.out_id = slot_id[rd_ptr];
                        r.out_offset = off[15:0];
                        r.out_len = len;
                        rd_ptr = (rd_ptr + 1) % MSG_SLOTS;
                        used--;
                        // zero-length messages give nothing back
                        if (len != 0)
                        begin
                            if (off < head_start)
                            begin
                                tail_start = head_start;
                                tail_room  = head_room;
                                head_start = off;
                                head_room  = {1'b0, len};
                            end
                            else
                                head_room = head_room + {1'b0, len};
                            head_end = head_start + head_room;
                            if (head_end == tail_start)
                            begin
                                head_room  = head_room + tail_room;
                                tail_start = 17'(BUF_BYTES);
                                tail_room  = '0;
                            end
                        end
                    end
                end
                vlmba_pkg::FN_CLEAR:
                begin
                    if (used == 0)
                        reset_regions();
                    else
                        r.status = vlmba_pkg::ST_IGNORED;
                end
                default:
                    r.status = vlmba_pkg::ST_IGNORED;
            endcase
            r.queue_empty = (used == 0);
            r.queue_full  = (used >= MSG_SLOTS);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(vlmba_pkg::result_t got);
            vlmba_pkg::result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_id", want.out_id, got.out_id);
            compare_field("out_offset", want.out_offset, got.out_offset);
            compare_field("out_len", want.out_len, got.out_len);
            compare_field("queue_empty", want.queue_empty, got.queue_empty);
            compare_field("queue_full", want.queue_full, got.queue_full);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    vlmba_pkg::cmd_t    cmd;
    logic               busy;
    logic               done;
    vlmba_pkg::result_t result;

    msg_alloc_tracker sb;

    variable_length_message_buffer_allocator_top #(
        .BUF_BYTES(BUF_BYTES),
        .MSG_SLOTS(MSG_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Holds start high until the block takes the transaction.
    task automatic issue(vlmba_pkg::cmd_t c);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_command(c);
    endtask

    task automatic send(logic [1:0] f, logic [31:0] id, logic [15:0] len);
        vlmba_pkg::cmd_t c;
        c.func = f;
        c.msg_id = id;
        c.msg_len = len;
        issue(c);
    endtask

    task automatic hold_until_drained();
        idle_cycle();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(int n, int idle_pct);
        traffic_t        mode;
        vlmba_pkg::cmd_t c;
        int              put_pct;
        int              p;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                mode = traffic_t'($urandom_range(2));
            put_pct = (mode == FILLING) ? 85 : (mode == DRAINING) ? 15 : 50;
            if ($urandom_range(99) == 0)
                hold_until_drained();
            while ($urandom_range(99) < idle_pct)
                idle_cycle();
            c.msg_id = $urandom();
            c.msg_len = 16'($urandom_range(65535));
            p = $urandom_range(99);
            if (p < 3)
                c.func = vlmba_pkg::FN_CLEAR;
            else if (p < 5)
                c.func = FN_UNUSED;
            else if ($urandom_range(99) < put_pct)
            begin
                c.func = vlmba_pkg::FN_PUT;
                p = $urandom_range(99);
                // filling runs need short messages to reach a full queue
                if ((mode == FILLING && p < 90) || p < 50)
                    c.msg_len = 16'($urandom_range(255));
                else if (p < 75)
                    c.msg_len = 16'($urandom_range(4095));
                else if (p < 87)
                    c.msg_len = 16'($urandom_range(32767));
                else if (p < 95)
                    c.msg_len = 16'($urandom_range(65535, 32768));
                else if (p < 98)
                    c.msg_len = '0;
                else
                    c.msg_len = 16'hFFFF;
            end
            else
                c.func = vlmba_pkg::FN_GET;
            issue(c);
        end
    endtask

    initial
    begin
        int guard;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue corner cases
        send(vlmba_pkg::FN_GET, 32'h0000_0001, 16'h0000);
        send(vlmba_pkg::FN_CLEAR, 32'h0, 16'h0);
        send(FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        // zero-length, whole-buffer, no room and a zero-length fit in the last byte
        send(vlmba_pkg::FN_PUT, 32'h0000_0000, 16'h0000);
        send(vlmba_pkg::FN_PUT, 32'hFFFF_FFFF, 16'hFFFF);
        send(vlmba_pkg::FN_PUT, 32'h1234_5678, 16'h0001);
        send(vlmba_pkg::FN_PUT, 32'hA5A5_5A5A, 16'h0000);
        send(vlmba_pkg::FN_CLEAR, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        // wrap into the tail region, then fall back to the head, then merge back
        send(vlmba_pkg::FN_PUT, 32'h0000_1000, 16'd1000);
        send(vlmba_pkg::FN_PUT, 32'h0000_2000, 16'd1000);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_PUT, 32'h0000_3000, 16'd500);
        send(vlmba_pkg::FN_PUT, 32'h0000_4000, 16'd63000);
        send(vlmba_pkg::FN_PUT, 32'h0000_5000, 16'd100);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_GET, 32'h0, 16'h0);
        send(vlmba_pkg::FN_CLEAR, 32'h0, 16'h0);
        hold_until_drained();

        run_random(670, 9);
        hold_until_drained();
        run_random(670, 55);
        hold_until_drained();
        run_random(670, 0);

        idle_cycle();
        guard = 0;
        while (sb.pending.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending.size() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
